FILE: rtl/core/ring_shuffle_buffer_assert.svh
// Assertion macros for the ring shuffle buffer.
// Used by ring_shuffle_buffer.sv; expects clk_i and rst_ni in scope.
`ifndef RING_SHUFFLE_BUFFER_ASSERT_SVH
`define RING_SHUFFLE_BUFFER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RSB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rsb_pkg.sv
// Shared types and constants for the ring shuffle buffer.
// No dependencies; imported by rsb_mod_unit and ring_shuffle_buffer.
`timescale 1ns / 1ps
`default_nettype none

package rsb_pkg;

  // Fixed field widths.
  localparam int unsigned BS_W    = 7;   // batch_size register
  localparam int unsigned SLOTS_W = 11;  // buffer_slots register
  localparam int unsigned LEN_W   = 11;  // batch_length field
  localparam int unsigned CFG_W   = 11;  // config write data
  localparam int unsigned IDX_W   = 2;   // config register index
  localparam int unsigned RAND_W  = 32;  // random_value field
  localparam int unsigned WORD_W  = 32;  // handle fields on the ports
  localparam int unsigned ST_W    = 2;   // status field

  // Config register indexes.
  localparam logic [IDX_W-1:0] CFG_BATCH_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BUFFER_SLOTS = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HAS_TARGET   = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BUSY    = 2'd3;

  // Action codes.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_SEL,
    S_WR,
    S_RD,
    S_SWAP1,
    S_SWAP2,
    S_RESP,
    S_PRD,
    S_POUT
  } rsb_state_e;

  // Status of the shared modulo unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rsb_div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the handle pairs of the ring shuffle buffer.
`timescale 1ns / 1ps
`default_nettype none

module rsb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsb_mod_unit.sv
// Bit-serial restoring modulo unit: remainder of a 32-bit value by a divisor.
// Depends on rsb_pkg (status struct); one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rsb_mod_unit #(
  parameter int unsigned MOD_W = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rsb_pkg::RAND_W-1:0]    dividend_i,
  input  wire logic [MOD_W-1:0]              divisor_i,
  output rsb_pkg::rsb_div_stat_t             stat_o,
  output logic      [MOD_W-1:0]              rem_o
);

  import rsb_pkg::*;

  localparam int unsigned CNT_W = $clog2(RAND_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAND_W-1:0] quo_q;
  logic [MOD_W-1:0]  div_q;
  logic [MOD_W-1:0]  rem_q;
  logic [MOD_W:0]    shifted;
  logic [MOD_W:0]    trial;

  // Remainder stays below the divisor, so shift-in fits MOD_W+1 bits.
  assign shifted = {rem_q, quo_q[RAND_W-1]};
  assign trial   = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RAND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[RAND_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_q <= trial[MOD_W-1:0];
      end else begin
        rem_q <= shifted[MOD_W-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/ring_shuffle_buffer.sv
// Ring shuffle buffer top level: sequencer, ring pointers, output register.
// Depends on rsb_pkg, rsb_mod_unit, rsb_ram and ring_shuffle_buffer_assert.svh.
//
// Usage:
//   s_axis carries one item per handshake: tuser = action (0 push, 1 pop);
//   tdata = input_word, target_word, batch_length, shuffle_enable, random_value.
//   m_axis returns results: tuser = status, tdata = out_input_word,
//   out_target_word, tlast = last_of_run. A push gives one result; a pop gives
//   min(batch_size clamped to 1..MAX_BATCH, fill) elements, or one empty or busy status.
//   cfg_* writes one of batch_size, buffer_slots, has_target, chosen by cfg_idx_i;
//   a write of buffer_slots empties the ring and drops a batch in progress.
// Sequencing:
//   One item at a time; s_axis_tready is high only while the sequencer idles.
//   An unshuffled push writes the ring RAM once. A shuffled push waits on the
//   32-step bit-serial modulo unit, plus a read and two writes of the ring RAM
//   when a swap is taken. A pop reads its elements one after another through
//   the single registered read port of the ring RAM; busy and empty answers read none.
//   Results sit in an output register, so the next item is accepted while the
//   last result waits; a stalled m_axis holds the sequencer at its next result.
// Reset: pointers, counts and batch state clear; registers return to
//   batch_size 1, buffer_slots 1024, has_target 1. RAM contents are undefined
//   and need no clearing pass: only committed slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ring_shuffle_buffer #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned MAX_BATCH   = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input items.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] input_word, [63:32] target_word, [74:64] batch_length,
  // [75] shuffle_enable, [107:76] random_value, [111:108] zero
  input  wire logic [111:0]                s_axis_tdata,
  // [0] action
  input  wire logic                        s_axis_tuser,
  // Result items.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [31:0] out_input_word, [63:32] out_target_word
  output logic      [63:0]                 m_axis_tdata,
  // [1:0] status
  output logic      [rsb_pkg::ST_W-1:0]    m_axis_tuser,
  output logic                             m_axis_tlast,
  // Configuration writes.
  input  wire logic                        cfg_we_i,
  input  wire logic [rsb_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rsb_pkg::CFG_W-1:0]   cfg_wdata_i
);

  import rsb_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);          // ring index
  localparam int unsigned FW = $clog2(CAPACITY + 1);      // fill count
  localparam int unsigned LW = $clog2(CAPACITY + 2048);   // fill + batch length
  localparam int unsigned HB = HANDLE_BITS;
  localparam int unsigned XW = (HB > WORD_W) ? HB : WORD_W;
  localparam int unsigned PW = 2 * HB;                    // RAM pair width

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [BS_W-1:0]    bs_q;
  logic [SLOTS_W-1:0] slots_q;
  logic               has_tgt_q;
  logic               flush;

  assign flush = cfg_we_i && (cfg_idx_i == CFG_BUFFER_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q      <= BS_W'(1);
      slots_q   <= SLOTS_W'(1024);
      has_tgt_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BATCH_SIZE:   bs_q      <= cfg_wdata_i[BS_W-1:0];
        CFG_BUFFER_SLOTS: slots_q   <= cfg_wdata_i[SLOTS_W-1:0];
        CFG_HAS_TARGET:   has_tgt_q <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  // Effective ring capacity and pop size, clamped.
  logic [LW-1:0]   cap_w;
  logic [BS_W-1:0] pop_sz;

  always_comb begin
    cap_w = LW'(slots_q);
    if (cap_w == '0) begin
      cap_w = LW'(1);
    end else if (cap_w > LW'(CAPACITY)) begin
      cap_w = LW'(CAPACITY);
    end
    pop_sz = bs_q;
    if (pop_sz == '0) begin
      pop_sz = BS_W'(1);
    end else if (pop_sz > BS_W'(MAX_BATCH)) begin
      pop_sz = BS_W'(MAX_BATCH);
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  rsb_state_e       state_q, state_d;
  logic [AW-1:0]    head_q, tail_q;
  logic [FW-1:0]    fill_q;
  logic [LEN_W-1:0] pend_q;
  logic [LEN_W-1:0] cur_len_q;
  logic             reject_q;

  // Latched item.
  logic [HB-1:0]     in_h_q, tgt_h_q;
  logic [LEN_W-1:0]  len_q;
  logic              shuf_q;
  logic [RAND_W-1:0] rand_q;

  // Per-item working registers.
  logic [AW-1:0]     slot_q, other_q, rp_q;
  logic [ST_W-1:0]   resp_q;
  logic              act_q;
  logic [BS_W-1:0]   n_q, cnt_q;

  // Output register.
  logic              out_valid_q;
  logic [ST_W-1:0]   out_st_q;
  logic [WORD_W-1:0] out_iw_q, out_tw_q;
  logic              out_last_q;
  logic              out_free;

  logic              in_fire;
  logic [XW-1:0]     in_ext, tgt_ext;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_ext   = XW'(s_axis_tdata[31:0]);
  assign tgt_ext  = XW'(s_axis_tdata[63:32]);

  // ---------------------------------------------------------------------------
  // Push preparation: batch length, space check and write slot
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] prep_len;
  logic             prep_rej;
  logic [LW-1:0]    slot_sum, slot_wrap;

  always_comb begin
    if (pend_q == '0) begin
      prep_len = (len_q == '0) ? LEN_W'(1) : len_q;
      prep_rej = (cap_w - LW'(fill_q)) < LW'(prep_len);
    end else begin
      prep_len = cur_len_q;
      prep_rej = reject_q;
    end
    // tail + pending stays below twice the capacity when accepted.
    slot_sum  = LW'(tail_q) + LW'(pend_q);
    slot_wrap = (slot_sum >= cap_w) ? (slot_sum - cap_w) : slot_sum;
  end

  // ---------------------------------------------------------------------------
  // Shared modulo unit
  // ---------------------------------------------------------------------------
  logic          div_start;
  rsb_div_stat_t div_stat;
  logic [LW-1:0] div_rem;
  logic [LW-1:0] other_sum, other_wrap;

  rsb_mod_unit #(
    .MOD_W (LW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rand_q),
    .divisor_i  (LW'(fill_q) + LW'(prep_len)),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // Swap partner: head + r with r below fill.
  assign other_sum  = LW'(head_q) + div_rem;
  assign other_wrap = (other_sum >= cap_w) ? (other_sum - cap_w) : other_sum;

  // ---------------------------------------------------------------------------
  // Ring RAM: {target, input} pairs
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_wdata, ram_rdata;

  rsb_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Pop helpers
  // ---------------------------------------------------------------------------
  logic          pop_last;
  logic [AW-1:0] rp_next;
  logic [XW-1:0] rd_in_ext, rd_tgt_ext;

  assign pop_last   = (cnt_q + BS_W'(1)) == n_q;
  assign rp_next    = (LW'(rp_q) + LW'(1) == cap_w) ? '0 : rp_q + AW'(1);
  assign rd_in_ext  = XW'(ram_rdata[HB-1:0]);
  assign rd_tgt_ext = XW'(ram_rdata[PW-1:HB]);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic              out_load;
  logic [ST_W-1:0]   out_st_d;
  logic [WORD_W-1:0] out_iw_d, out_tw_d;
  logic              out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    ram_wdata  = {tgt_h_q, in_h_q};
    ram_re     = 1'b0;
    ram_raddr  = rp_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_st_d   = resp_q;
    out_iw_d   = '0;
    out_tw_d   = '0;
    out_last_d = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == ACT_PUSH) begin
            state_d = S_PREP;
          end else if ((pend_q != '0) || (fill_q == '0)) begin
            state_d = S_RESP;
          end else begin
            state_d = S_PRD;
          end
        end
      end
      S_PREP: begin
        if (prep_rej) begin
          state_d = S_RESP;
        end else if (shuf_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_WR;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        state_d = (div_rem < LW'(fill_q)) ? S_RD : S_WR;
      end
      S_WR: begin
        ram_we  = 1'b1;
        state_d = S_RESP;
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = other_q;
        state_d   = S_SWAP1;
      end
      S_SWAP1: begin
        // New pair goes into the committed slot it displaces.
        ram_we    = 1'b1;
        ram_waddr = other_q;
        state_d   = S_SWAP2;
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_PRD: begin
        ram_re  = 1'b1;
        state_d = S_POUT;
      end
      S_POUT: begin
        out_st_d   = ST_OK;
        out_iw_d   = rd_in_ext[WORD_W-1:0];
        out_tw_d   = has_tgt_q ? rd_tgt_ext[WORD_W-1:0] : '0;
        out_last_d = pop_last;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pop_last ? S_IDLE : S_PRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Ring and batch bookkeeping
  // ---------------------------------------------------------------------------
  logic [LEN_W:0] pend_inc;
  logic [LW-1:0]  tail_sum, tail_wrap;

  assign pend_inc  = {1'b0, pend_q} + (LEN_W + 1)'(1);
  assign tail_sum  = LW'(tail_q) + LW'(cur_len_q);
  assign tail_wrap = (tail_sum >= cap_w) ? (tail_sum - cap_w) : tail_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      pend_q    <= '0;
      cur_len_q <= '0;
      reject_q  <= 1'b0;
    end else if (flush) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      pend_q    <= '0;
      cur_len_q <= '0;
      reject_q  <= 1'b0;
    end else begin
      case (state_q)
        S_PREP: begin
          cur_len_q <= prep_len;
          reject_q  <= prep_rej;
        end
        S_RESP: begin
          if (out_free && (act_q == ACT_PUSH)) begin
            if (pend_inc >= {1'b0, cur_len_q}) begin
              // Batch complete: commit unless it was turned away.
              if (!reject_q) begin
                tail_q <= tail_wrap[AW-1:0];
                fill_q <= fill_q + FW'(cur_len_q);
              end
              pend_q    <= '0;
              cur_len_q <= '0;
              reject_q  <= 1'b0;
            end else begin
              pend_q <= pend_inc[LEN_W-1:0];
            end
          end
        end
        S_POUT: begin
          if (out_free && pop_last) begin
            head_q <= rp_next;
            fill_q <= fill_q - FW'(n_q);
          end
        end
        default: ;
      endcase
    end
  end

  // Item latch and per-item working registers (payload, no reset).
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_h_q  <= in_ext[HB-1:0];
      tgt_h_q <= tgt_ext[HB-1:0];
      len_q   <= s_axis_tdata[74:64];
      shuf_q  <= s_axis_tdata[75];
      rand_q  <= s_axis_tdata[107:76];
      act_q   <= s_axis_tuser;
      rp_q    <= head_q;
      cnt_q   <= '0;
      n_q     <= (LW'(pop_sz) > LW'(fill_q)) ? BS_W'(fill_q) : pop_sz;
      resp_q  <= (pend_q != '0) ? ST_BUSY : ST_EMPTY;
    end
    if (state_q == S_PREP) begin
      slot_q <= slot_wrap[AW-1:0];
      resp_q <= prep_rej ? ST_NOSPACE : ST_OK;
    end
    if (state_q == S_SEL) begin
      other_q <= other_wrap[AW-1:0];
    end
    if ((state_q == S_POUT) && out_free) begin
      rp_q  <= rp_next;
      cnt_q <= cnt_q + BS_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q   <= out_st_d;
      out_iw_q   <= out_iw_d;
      out_tw_q   <= out_tw_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_tw_q, out_iw_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "ring_shuffle_buffer_assert.svh"

  `RSB_ASSERT_IMP(a_fill_bound, 1'b1, LW'(fill_q) <= cap_w, "fill exceeds ring capacity")
  `RSB_ASSERT_IMP(a_pend_bound, pend_q != '0, pend_q < cur_len_q, "pending past batch length")
  `RSB_ASSERT_IMP(a_div_owned, div_stat.busy || div_stat.done, state_q == S_DIV,
                  "modulo unit active outside its wait state")
  `RSB_ASSERT_NXT(a_swap_pair, state_q == S_SWAP1, ram_we && (state_q == S_SWAP2),
                  "swap not completed by second write")

endmodule

`default_nettype wire
